@@ rtl/core/size_class_page_slab_allocator_core_macros.svh @@
// ----------------------------------------------------------------------------
// Slab allocator assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_PAGE_SLAB_ALLOCATOR_CORE_MACROS_SVH
`define SIZE_CLASS_PAGE_SLAB_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/scpsa_pkg.sv @@
// ----------------------------------------------------------------------------
// Slab allocator package
// Arena geometry, codes, page word layout and run bound helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scpsa_pkg;

	localparam int PAGE_BYTES    = 4096;
	localparam int NUM_PAGES     = 64;
	localparam int GRANULE_BYTES = 8;

	localparam int DATA_PAGES = NUM_PAGES - 1;
	localparam int GPP        = PAGE_BYTES / GRANULE_BYTES;
	localparam int PAGE_W     = $clog2(DATA_PAGES);
	localparam int GIDX_W     = $clog2(GPP);
	localparam int GSH_W      = $clog2(GRANULE_BYTES);
	localparam int ADDR_W     = 18;
	localparam int CNT_W      = 10;
	localparam int CFG_W      = 6;
	localparam int LINK_DEPTH = DATA_PAGES * GPP;
	localparam int LINK_AW    = PAGE_W + GIDX_W;

	localparam logic [CNT_W-1:0] SLOTS_HUGE   = CNT_W'(PAGE_BYTES / 32);
	localparam logic [CNT_W-1:0] SLOTS_LARGE  = CNT_W'(PAGE_BYTES / 24);
	localparam logic [CNT_W-1:0] SLOTS_MEDIUM = CNT_W'(PAGE_BYTES / 16);
	localparam logic [CNT_W-1:0] SLOTS_SMALL  = CNT_W'(PAGE_BYTES / 8);

	localparam logic [GIDX_W-1:0] STEP_HUGE   = GIDX_W'(32 / GRANULE_BYTES);
	localparam logic [GIDX_W-1:0] STEP_LARGE  = GIDX_W'(24 / GRANULE_BYTES);
	localparam logic [GIDX_W-1:0] STEP_MEDIUM = GIDX_W'(16 / GRANULE_BYTES);
	localparam logic [GIDX_W-1:0] STEP_SMALL  = GIDX_W'(8 / GRANULE_BYTES);

	typedef logic [3:0][CFG_W-1:0] cfg_t;
	localparam cfg_t CFG_RESET = {6'd13, 6'd19, 6'd19, 6'd12};

	localparam logic [1:0] CLS_HUGE   = 2'd0;
	localparam logic [1:0] CLS_LARGE  = 2'd1;
	localparam logic [1:0] CLS_MEDIUM = 2'd2;
	localparam logic [1:0] CLS_SMALL  = 2'd3;

	localparam logic [2:0] STAT_GRANTED   = 3'd0;
	localparam logic [2:0] STAT_TOO_LARGE = 3'd1;
	localparam logic [2:0] STAT_EXHAUSTED = 3'd2;
	localparam logic [2:0] STAT_FREED     = 3'd3;
	localparam logic [2:0] STAT_OUTSIDE   = 3'd4;

	localparam logic FUNC_ALLOC = 1'b0;

	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic [GIDX_W-1:0] head;
	} page_word_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_FILL, S_PREAD, S_POP1, S_POP2, S_SCAN, S_FREE_WR, S_DONE
	} state_t;

	function automatic logic [CNT_W-1:0] slot_count(input logic [1:0] c);
		logic [CNT_W-1:0] n;
		unique case (c)
			CLS_HUGE:   n = SLOTS_HUGE;
			CLS_LARGE:  n = SLOTS_LARGE;
			CLS_MEDIUM: n = SLOTS_MEDIUM;
			default:    n = SLOTS_SMALL;
		endcase
		return n;
	endfunction

	function automatic logic [GIDX_W-1:0] gran_step(input logic [1:0] c);
		logic [GIDX_W-1:0] s;
		unique case (c)
			CLS_HUGE:   s = STEP_HUGE;
			CLS_LARGE:  s = STEP_LARGE;
			CLS_MEDIUM: s = STEP_MEDIUM;
			default:    s = STEP_SMALL;
		endcase
		return s;
	endfunction

	function automatic logic [PAGE_W-1:0] clamp_page(input logic [CFG_W+1:0] v);
		return (v < (CFG_W+2)'(DATA_PAGES)) ? PAGE_W'(v) : PAGE_W'(DATA_PAGES);
	endfunction

	function automatic logic [CFG_W+1:0] run_start(input cfg_t cfg, input logic [1:0] c);
		logic [CFG_W+1:0] s;
		s = '0;
		for (int i = 0; i < 4; i++) begin
			if (i < int'(c)) s = s + (CFG_W+2)'(cfg[i]);
		end
		return s;
	endfunction

	function automatic logic [PAGE_W-1:0] run_lo(input cfg_t cfg, input logic [1:0] c);
		return clamp_page(run_start(cfg, c));
	endfunction

	function automatic logic [PAGE_W-1:0] run_hi(input cfg_t cfg, input logic [1:0] c);
		return clamp_page(run_start(cfg, c) + (CFG_W+2)'(cfg[c]));
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/size_class_page_slab_allocator_core.sv @@
// ----------------------------------------------------------------------------
// Size-class page slab allocator core
// Grants and frees fixed slots of four size classes in a paged arena.
// ----------------------------------------------------------------------------
// One word in, one word out. Allocate requests map to the 32, 24, 16 or 8 byte
// class; the class hot page hands out the head of its LIFO free list. Free
// requests push the slot back onto the list of the page that holds it. Page
// state (free count and list head) lives in a 63-entry page memory, the slot
// links in a 32256-entry link memory; both have a registered read.
// Items are handled one at a time. Bringing a fresh page into use first
// sweeps its slot links through the link memory, one slot per cycle, then
// rereads the page word. When the hot page empties, a rescan reads the page
// counts of the class from the page memory one per cycle. No clearing pass
// runs after reset.
// A register write resets the class bookkeeping under the new page layout.
`timescale 1ns / 1ps
`default_nettype none
`include "size_class_page_slab_allocator_core_macros.svh"

module size_class_page_slab_allocator_core
	import scpsa_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// func[0], request_size[16:1], free_address[34:17], zero pad[39:35]
	input  wire logic [39:0]      s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// status[2:0], slot_address[20:3], size_class[22:21], zero pad[23]
	output logic [23:0]           m_tdata
);

	// configuration and class bookkeeping
	cfg_t                          cfg_q;
	cfg_t                          cfg_new;
	logic [3:0][PAGE_W-1:0]        next_unused_q;
	logic [3:0][PAGE_W-1:0]        hot_page_q;
	logic [3:0]                    hot_valid_q;
	logic [3:0][PAGE_W-1:0]        lo_w;
	logic [3:0][PAGE_W-1:0]        hi_w;

	// item registers
	state_t                        state_q, state_d;
	logic                          func_q;
	logic [15:0]                   size_q;
	logic [ADDR_W-1:0]             addr_q;
	logic [1:0]                    cls_q;
	logic [PAGE_W-1:0]             pg_q;
	logic [CNT_W-1:0]              k_q;
	logic [GIDX_W-1:0]             g_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [2:0]                    res_status_q;
	logic [ADDR_W-1:0]             res_addr_q;
	logic [1:0]                    res_cls_q;

	// rescan registers
	logic [PAGE_W-1:0]             ptr_q;
	logic                          pend_s1;
	logic [PAGE_W-1:0]             idx_s1;
	logic [PAGE_W-1:0]             best_q;
	logic [CNT_W-1:0]              bestcnt_q;
	logic                          found_q;

	// output register
	logic                          out_valid_q;
	logic [23:0]                   out_data_q;

	// memories
	page_word_t                    page_mem [0:DATA_PAGES-1];
	logic [GIDX_W-1:0]             link_mem [0:LINK_DEPTH-1];
	page_word_t                    pg_rdata;
	logic [GIDX_W-1:0]             lk_rdata;
	logic [PAGE_W-1:0]             pg_raddr;
	logic                          pg_we;
	logic [PAGE_W-1:0]             pg_waddr;
	page_word_t                    pg_wdata;
	logic [LINK_AW-1:0]            lk_raddr;
	logic                          lk_we;
	logic [LINK_AW-1:0]            lk_waddr;
	logic [GIDX_W-1:0]             lk_wdata;

	// decode helpers
	logic [1:0]                    cls_d;
	logic                          too_large;
	logic [PAGE_W-1:0]             free_pg;
	logic [GIDX_W-1:0]             free_g;
	logic                          fill_last;
	logic [CNT_W-1:0]              cnt_dec;
	logic                          scan_issue;
	logic                          scan_upd;
	logic [PAGE_W-1:0]             nbest;
	logic [CNT_W-1:0]              nbestcnt;
	logic                          nfound;
	logic                          scan_finish;
	logic [1:0]                    free_cls;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// run bounds of the live layout
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			lo_w[c] = run_lo(cfg_q, 2'(c));
			hi_w[c] = run_hi(cfg_q, 2'(c));
		end
	end

	always_comb begin
		cfg_new = cfg_q;
		cfg_new[cfg_index] = cfg_data;
	end

	// size to class: smallest class that fits
	always_comb begin
		too_large = (size_q > 16'd32);
		priority if (size_q <= 16'd8)  cls_d = CLS_SMALL;
		else if (size_q <= 16'd16)     cls_d = CLS_MEDIUM;
		else if (size_q <= 16'd24)     cls_d = CLS_LARGE;
		else                           cls_d = CLS_HUGE;
	end

	assign free_pg   = addr_q[ADDR_W-1 -: PAGE_W];
	assign free_g    = addr_q[GSH_W +: GIDX_W];
	assign fill_last = (k_q == slot_count(cls_q) - CNT_W'(1));
	assign cnt_dec   = cnt_q - CNT_W'(1);

	// owning class of a freed page: first run whose end lies above it
	always_comb begin
		priority if (free_pg < hi_w[0]) free_cls = CLS_HUGE;
		else if (free_pg < hi_w[1])     free_cls = CLS_LARGE;
		else if (free_pg < hi_w[2])     free_cls = CLS_MEDIUM;
		else                            free_cls = CLS_SMALL;
	end

	// rescan: keep the first page with the greatest count, stop at a full page
	always_comb begin
		scan_issue = (ptr_q < next_unused_q[cls_q]);
		scan_upd   = pend_s1 && (pg_rdata.cnt > bestcnt_q);
		nbest      = scan_upd ? idx_s1 : best_q;
		nbestcnt   = scan_upd ? pg_rdata.cnt : bestcnt_q;
		nfound     = found_q || scan_upd;
		scan_finish = (nfound && (nbestcnt == slot_count(cls_q))) ||
			(!scan_issue && !pend_s1);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (func_q == FUNC_ALLOC) begin
					priority if (too_large)
						state_d = S_DONE;
					else if (!hot_valid_q[cls_d])
						state_d = (next_unused_q[cls_d] >= hi_w[cls_d]) ? S_DONE : S_FILL;
					else if (hot_page_q[cls_d] >= PAGE_W'(DATA_PAGES))
						state_d = S_DONE;
					else
						state_d = S_POP1;
				end else begin
					state_d = (free_pg >= hi_w[CLS_SMALL]) ? S_DONE : S_FREE_WR;
				end
			end
			S_FILL: begin
				if (fill_last) state_d = S_PREAD;
			end
			S_PREAD:   state_d = S_POP1;
			S_POP1:    state_d = S_POP2;
			S_POP2:    state_d = (cnt_dec == '0) ? S_SCAN : S_DONE;
			S_SCAN: begin
				if (scan_finish) state_d = S_DONE;
			end
			S_FREE_WR: state_d = S_DONE;
			S_DONE: begin
				if (!out_valid_q || m_tready) state_d = S_IDLE;
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		pg_raddr = pg_q;
		pg_we    = 1'b0;
		pg_waddr = pg_q;
		pg_wdata = '0;
		lk_raddr = {pg_q, pg_rdata.head};
		lk_we    = 1'b0;
		lk_waddr = {pg_q, g_q};
		lk_wdata = '0;
		unique case (state_q)
			S_DECODE: begin
				pg_raddr = (func_q == FUNC_ALLOC) ? hot_page_q[cls_d] : free_pg;
			end
			S_FILL: begin
				lk_we    = 1'b1;
				lk_wdata = fill_last ? '0 : g_q + gran_step(cls_q);
				if (fill_last) begin
					pg_we    = 1'b1;
					pg_wdata = '{cnt: slot_count(cls_q), head: '0};
				end
			end
			S_POP2: begin
				pg_we    = 1'b1;
				pg_wdata = '{cnt: cnt_dec, head: lk_rdata};
			end
			S_SCAN: begin
				pg_raddr = ptr_q;
			end
			S_FREE_WR: begin
				pg_waddr = free_pg;
				pg_we    = 1'b1;
				pg_wdata = '{cnt: pg_rdata.cnt + CNT_W'(1), head: free_g};
				lk_we    = 1'b1;
				lk_waddr = {free_pg, free_g};
				lk_wdata = pg_rdata.head;
			end
			default: begin
			end
		endcase
	end

	// page memory: registered read
	always_ff @(posedge clk) begin
		if (pg_we) page_mem[pg_waddr] <= pg_wdata;
		if (pg_raddr < PAGE_W'(DATA_PAGES)) pg_rdata <= page_mem[pg_raddr];
	end

	// link memory: registered read
	always_ff @(posedge clk) begin
		if (lk_we) link_mem[lk_waddr] <= lk_wdata;
		lk_rdata <= link_mem[lk_raddr];
	end

	// control state and class bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cfg_q       <= CFG_RESET;
			hot_valid_q <= '0;
			hot_page_q  <= '0;
			out_valid_q <= 1'b0;
			pend_s1     <= 1'b0;
			for (int c = 0; c < 4; c++) next_unused_q[c] <= run_lo(CFG_RESET, 2'(c));
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				// reinitialize the class bookkeeping under the new layout
				cfg_q       <= cfg_new;
				hot_valid_q <= '0;
				hot_page_q  <= '0;
				for (int c = 0; c < 4; c++) next_unused_q[c] <= run_lo(cfg_new, 2'(c));
			end
			if (state_q == S_FILL && fill_last) begin
				hot_page_q[cls_q]    <= pg_q;
				hot_valid_q[cls_q]   <= 1'b1;
				next_unused_q[cls_q] <= pg_q + PAGE_W'(1);
			end
			if (state_q == S_SCAN && scan_finish) begin
				hot_page_q[cls_q]  <= nfound ? nbest : '0;
				hot_valid_q[cls_q] <= nfound;
			end
			pend_s1 <= (state_q == S_SCAN) && scan_issue;
			// load a new result word, or drop the old one once taken
			if (state_q == S_DONE && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					func_q <= s_tdata[0];
					size_q <= s_tdata[16:1];
					addr_q <= s_tdata[34:17];
				end
			end
			S_DECODE: begin
				cls_q      <= cls_d;
				res_addr_q <= '0;
				k_q        <= '0;
				g_q        <= '0;
				pg_q       <= hot_valid_q[cls_d] ? hot_page_q[cls_d] : next_unused_q[cls_d];
				if (func_q == FUNC_ALLOC) begin
					priority if (too_large) begin
						res_status_q <= STAT_TOO_LARGE;
						res_cls_q    <= CLS_HUGE;
					end else if (!hot_valid_q[cls_d] &&
						next_unused_q[cls_d] >= hi_w[cls_d]) begin
						res_status_q <= STAT_EXHAUSTED;
						res_cls_q    <= cls_d;
					end else if (hot_valid_q[cls_d] &&
						hot_page_q[cls_d] >= PAGE_W'(DATA_PAGES)) begin
						res_status_q <= STAT_EXHAUSTED;
						res_cls_q    <= cls_d;
					end else begin
						res_status_q <= STAT_GRANTED;
						res_cls_q    <= cls_d;
					end
				end else if (free_pg >= hi_w[CLS_SMALL]) begin
					res_status_q <= STAT_OUTSIDE;
					res_cls_q    <= CLS_HUGE;
				end else begin
					res_status_q <= STAT_GRANTED;
					res_cls_q    <= cls_d;
				end
			end
			S_FILL: begin
				// advance one slot per cycle
				k_q <= k_q + CNT_W'(1);
				g_q <= g_q + gran_step(cls_q);
			end
			S_POP1: begin
				cnt_q      <= pg_rdata.cnt;
				res_addr_q <= {pg_q, pg_rdata.head, GSH_W'(0)};
			end
			S_POP2: begin
				ptr_q     <= lo_w[cls_q];
				best_q    <= '0;
				bestcnt_q <= '0;
				found_q   <= 1'b0;
			end
			S_SCAN: begin
				if (scan_issue) ptr_q <= ptr_q + PAGE_W'(1);
				best_q    <= nbest;
				bestcnt_q <= nbestcnt;
				found_q   <= nfound;
			end
			S_FREE_WR: begin
				res_status_q <= STAT_FREED;
				res_addr_q   <= addr_q;
				res_cls_q    <= free_cls;
			end
			S_DONE: begin
				if (!out_valid_q || m_tready)
					out_data_q <= {1'b0, res_cls_q, res_addr_q, res_status_q};
			end
			default: begin
			end
		endcase
	end

	// a hot page of the huge or small class is always one the class has already brought into use
	`ASSERT_IMP(a_hot_huge_used, hot_valid_q[0], hot_page_q[0] < next_unused_q[0], "hot page not in use")
	`ASSERT_IMP(a_hot_small_used, hot_valid_q[3], hot_page_q[3] < next_unused_q[3], "hot page not in use")
	// large-class page bring-in never runs past the end of its run
	`ASSERT_IMP(a_next_in_run, 1'b1, next_unused_q[1] <= hi_w[1], "next unused page beyond run")
	// a fresh page sweep stays inside the slot count of its class
	`ASSERT_IMP(a_fill_bound, state_q == S_FILL, k_q < slot_count(cls_q), "fill sweep overrun")

endmodule

`default_nettype wire
